// ----- rtl/core/srr_pkg.sv -----
// Shared constants, types and helper functions of the selective-repeat receiver.
// Used by the channel interfaces, the receiver top level and its checker.
package srr_pkg;

  localparam int WINDOW_SLOTS  = 32;
  localparam int SEGMENT_BYTES = 16;

  localparam int SEQ_W       = 16;
  localparam int LEN_W       = 5;
  localparam int WORD_W      = 64;
  localparam int BYTE_SHIFT  = 4;
  localparam int IDX_W       = SEQ_W - BYTE_SHIFT;
  localparam int SLOT_W      = $clog2(WINDOW_SLOTS);
  localparam int DATA_W      = 2 * WORD_W;
  localparam int SLOT_DATA_W = LEN_W + DATA_W;
  localparam int DATA_BYTES  = DATA_W / 8;

  typedef enum logic {
    KIND_DELIVER = 1'b0,
    KIND_ACK     = 1'b1
  } result_kind_e;

  // Clamp a segment length to the segment size.
  function automatic logic [LEN_W-1:0] sat_length(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(SEGMENT_BYTES);
    return (len > lim) ? lim : len;
  endfunction

  // Byte mask that keeps the bytes below the given (saturated) length.
  function automatic logic [DATA_W-1:0] keep_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < DATA_BYTES; b++) begin
      if (32'(len) > b) begin
        mask[b*8 +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

endpackage

// ----- rtl/core/srr_if.sv -----
// Valid/ready channel interfaces of the selective-repeat receiver.
// Depends on srr_pkg for the field widths.
interface srr_seg_if;
  import srr_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  seq_number;
  logic [LEN_W-1:0]  seg_length;
  logic [WORD_W-1:0] bytes_low;
  logic [WORD_W-1:0] bytes_high;

  modport source (output valid, seq_number, seg_length, bytes_low, bytes_high,
                  input ready);
  modport sink (input valid, seq_number, seg_length, bytes_low, bytes_high,
                output ready);
  modport monitor (input valid, ready, seq_number, seg_length, bytes_low,
                   bytes_high);
endinterface

interface srr_res_if;
  import srr_pkg::*;

  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [SEQ_W-1:0]  ack_number;
  logic [LEN_W-1:0]  out_length;
  logic [WORD_W-1:0] out_bytes_low;
  logic [WORD_W-1:0] out_bytes_high;
  logic              last_of_run;

  modport source (output valid, result_kind, ack_number, out_length, out_bytes_low,
                  out_bytes_high, last_of_run, input ready);
  modport sink (input valid, result_kind, ack_number, out_length, out_bytes_low,
                out_bytes_high, last_of_run, output ready);
  modport monitor (input valid, ready, result_kind, ack_number, out_length,
                   out_bytes_low, out_bytes_high, last_of_run);
endinterface

// ----- rtl/core/srr_slot_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// The read data holds its value until the next read. No dependencies.
module srr_slot_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [DATA_W-1:0]          wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [DATA_W-1:0]          rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/selective_repeat_receiver.sv -----
// Selective-repeat receiver top level: window check, slot store and in-order drain.
// Depends on srr_pkg, the srr_seg_if/srr_res_if interfaces and srr_slot_ram.
//
//   Channel  Direction  Beat contents
//   seg_i    in         seq_number, seg_length, bytes_low, bytes_high
//   res_o    out        result_kind, ack_number, out_length, out_bytes_low,
//                       out_bytes_high, last_of_run
//
// A segment that is stored or only acknowledged is accepted, and then the ack
// is loaded. A segment at the receive base is accepted and delivered, then each
// buffered slot behind it is drained by a slot RAM read followed by a load of
// the result register, and then the closing ack is loaded. Reset clears the
// receive base, the slot marks and the output valid flag; no clearing pass is
// needed. A stalled result holds in the output register and the state machine
// waits for it before loading the next.
module selective_repeat_receiver (
  input  logic     clk_i,
  input  logic     rst_ni,
  srr_seg_if.sink  seg_i,
  srr_res_if.source res_o
);
  import srr_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a segment
  localparam logic [2:0] ST_DELIV = 3'd1;  // deliver the in-order segment itself
  localparam logic [2:0] ST_CHECK = 3'd2;  // test the slot at the new base
  localparam logic [2:0] ST_LOAD  = 3'd3;  // move the read slot to the output
  localparam logic [2:0] ST_ACK   = 3'd4;  // emit the closing ack

  logic [2:0]              state_q, state_d;
  logic [IDX_W-1:0]        base_q, base_d;
  logic [SLOT_W-1:0]       base_slot_q, base_slot_d;
  logic [SLOT_W-1:0]       guard_q, guard_d;
  logic [WINDOW_SLOTS-1:0] filled_q, filled_d;

  // The segment being worked on.
  logic [SEQ_W-1:0]  seq_q;
  logic [LEN_W-1:0]  len_q;
  logic [DATA_W-1:0] data_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  result_kind_e      out_kind_q;
  logic [SEQ_W-1:0]  out_ack_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [DATA_W-1:0] out_data_q;

  // Incoming segment decode.
  logic              seg_acc;
  logic [IDX_W-1:0]  seg_idx;
  logic [IDX_W-1:0]  seg_offset;
  logic              at_base;
  logic              in_window;
  logic [LEN_W-1:0]  seg_len_sat;
  logic [DATA_W-1:0] seg_data;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] store_slot;
  logic [SLOT_W-1:0] next_slot;

  // Slot RAM ports.
  logic                   ram_we;
  logic                   ram_re;
  logic [SLOT_DATA_W-1:0] ram_wdata;
  logic [SLOT_DATA_W-1:0] ram_rdata;

  // Output load controls.
  logic out_free;
  logic load_deliver;
  logic load_slot;
  logic load_ack;

  assign seg_i.ready = (state_q == ST_IDLE);
  assign seg_acc     = seg_i.valid && seg_i.ready;

  // Window position of the segment, taken modulo the index space.
  assign seg_idx    = seg_i.seq_number[SEQ_W-1:BYTE_SHIFT];
  assign seg_offset = seg_idx - base_q;
  assign at_base    = (seg_offset == '0);
  assign in_window  = (seg_offset < IDX_W'(WINDOW_SLOTS));

  // Length saturates, and bytes at or past the length read as zero.
  assign seg_len_sat = sat_length(seg_i.seg_length);
  assign seg_data    = {seg_i.bytes_high, seg_i.bytes_low} & keep_mask(seg_len_sat);

  // Slot of an in-window segment; the sum stays below twice the window.
  assign slot_sum   = {1'b0, base_slot_q} + {1'b0, seg_offset[SLOT_W-1:0]};
  assign store_slot = (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS))
                      ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_SLOTS))
                      : slot_sum[SLOT_W-1:0];
  assign next_slot  = (base_slot_q == SLOT_W'(WINDOW_SLOTS - 1))
                      ? '0 : base_slot_q + SLOT_W'(1);

  // Store path: written in the accept cycle. A read of the same slot only
  // happens after the segment reaches the base, so write and read never meet.
  assign ram_we    = seg_acc && !at_base && in_window;
  assign ram_wdata = {seg_len_sat, seg_data};

  srr_slot_ram #(
    .DATA_W (SLOT_DATA_W),
    .DEPTH  (WINDOW_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (store_slot),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (base_slot_q),
    .rdata_o (ram_rdata)
  );

  assign out_free     = !out_valid_q || res_o.ready;
  assign load_deliver = (state_q == ST_DELIV) && out_free;
  assign load_slot    = (state_q == ST_LOAD) && out_free;
  assign load_ack     = (state_q == ST_ACK) && out_free;

  // Sequencer: deliver, walk marked slots one at a time, ack; off base, ack only.
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    base_slot_d = base_slot_q;
    guard_d     = guard_q;
    filled_d    = filled_q;
    ram_re      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (seg_acc) begin
          state_d = at_base ? ST_DELIV : ST_ACK;
          if (ram_we) begin
            filled_d[store_slot] = 1'b1;
          end
        end
      end
      ST_DELIV: begin
        if (out_free) begin
          base_d      = base_q + IDX_W'(1);
          base_slot_d = next_slot;
          guard_d     = '0;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (filled_q[base_slot_q] && (guard_q < SLOT_W'(WINDOW_SLOTS - 1))) begin
          ram_re                = 1'b1;
          filled_d[base_slot_q] = 1'b0;
          guard_d               = guard_q + SLOT_W'(1);
          state_d               = ST_LOAD;
        end else begin
          state_d = ST_ACK;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          base_d      = base_q + IDX_W'(1);
          base_slot_d = next_slot;
          state_d     = ST_CHECK;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_deliver || load_slot || load_ack) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      base_slot_q <= '0;
      guard_q     <= '0;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      base_slot_q <= base_slot_d;
      guard_q     <= guard_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (seg_acc) begin
      seq_q  <= seg_i.seq_number;
      len_q  <= seg_len_sat;
      data_q <= seg_data;
    end
    if (load_deliver) begin
      out_kind_q <= KIND_DELIVER;
      out_ack_q  <= '0;
      out_len_q  <= len_q;
      out_data_q <= data_q;
    end else if (load_slot) begin
      out_kind_q <= KIND_DELIVER;
      out_ack_q  <= '0;
      out_len_q  <= ram_rdata[SLOT_DATA_W-1 -: LEN_W];
      out_data_q <= ram_rdata[DATA_W-1:0];
    end else if (load_ack) begin
      out_kind_q <= KIND_ACK;
      out_ack_q  <= seq_q + SEQ_W'(1);
      out_len_q  <= '0;
      out_data_q <= '0;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.result_kind    = out_kind_q;
  assign res_o.ack_number     = out_ack_q;
  assign res_o.out_length     = out_len_q;
  assign res_o.out_bytes_low  = out_data_q[WORD_W-1:0];
  assign res_o.out_bytes_high = out_data_q[DATA_W-1:WORD_W];
  assign res_o.last_of_run    = (out_kind_q == KIND_ACK);

endmodule

// ----- rtl/core/srr_checker.sv -----
// Port-level checks of the selective-repeat receiver, bound to its top level.
// Depends on srr_pkg; the bind takes the beats from the srr_seg_if/srr_res_if ports.
module srr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       seg_valid_i,
  input logic                       seg_ready_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic                       res_kind_i,
  input logic [srr_pkg::SEQ_W-1:0]  res_ack_i,
  input logic [srr_pkg::LEN_W-1:0]  res_len_i,
  input logic [srr_pkg::WORD_W-1:0] res_lo_i,
  input logic [srr_pkg::WORD_W-1:0] res_hi_i
);
  import srr_pkg::*;

  // A stalled result beat holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i) &&
    $stable(res_ack_i) && $stable(res_len_i) &&
    $stable(res_lo_i) && $stable(res_hi_i))
    else $error("srr: stalled result beat changed");

  // Segments are taken one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_i && seg_ready_i |=> !seg_ready_i)
    else $error("srr: segment accepted while another is in work");

  // While a delivery waits, its closing ack is still owed, so no segment is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_DELIVER) |-> !seg_ready_i)
    else $error("srr: segment ready during a delivery run");

  // Leaving reset, no result is pending.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid_i)
    else $error("srr: result valid out of reset");

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .seg_valid_i (seg_i.valid),
  .seg_ready_i (seg_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_kind_i  (res_o.result_kind),
  .res_ack_i   (res_o.ack_number),
  .res_len_i   (res_o.out_length),
  .res_lo_i    (res_o.out_bytes_low),
  .res_hi_i    (res_o.out_bytes_high)
);
